// ----- rtl/convex_support_point_search_core_macros.svh -----
// Assertion macros for the convex support point search core checks.
`ifndef CONVEX_SUPPORT_POINT_SEARCH_CORE_MACROS_SVH
`define CONVEX_SUPPORT_POINT_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define CSPSS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cspss check failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define CSPSS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cspss check failed");

`endif

// ----- rtl/cspss_pkg.sv -----
// Shared types and constants for the convex support point search core.
`timescale 1ns / 1ps
`default_nettype none

package cspss_pkg;

   localparam int COEF_BITS      = 16;
   localparam int ROW_BITS       = 64;
   localparam int WORLD_BITS     = 32;
   localparam int DIR_BITS       = 16;
   localparam int COUNT_BITS     = 9;
   localparam int CSR_INDEX_BITS = 3;
   localparam int OFFSET_SHIFT   = 8;

   // item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_X        = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_Y        = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_Z        = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VERTEX_COUNT = 3'd3;

   // identity matrix, one vertex
   localparam logic [ROW_BITS-1:0]   ROW_X_RESET = 64'h0000_0000_0000_0100;
   localparam logic [ROW_BITS-1:0]   ROW_Y_RESET = 64'h0000_0000_0100_0000;
   localparam logic [ROW_BITS-1:0]   ROW_Z_RESET = 64'h0000_0100_0000_0000;
   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 9'd1;

   typedef struct packed {
      logic               kind;
      logic [7:0]         vert_index;
      logic signed [15:0] vert_x;
      logic signed [15:0] vert_y;
      logic signed [15:0] vert_z;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
   } req_word_type;

   typedef struct packed {
      logic signed [WORLD_BITS-1:0] point_x;
      logic signed [WORLD_BITS-1:0] point_y;
      logic signed [WORLD_BITS-1:0] point_z;
   } rsp_word_type;

   typedef struct packed {
      logic [CSR_INDEX_BITS-1:0] reg_index;
      logic [ROW_BITS-1:0]       reg_data;
   } csr_word_type;

endpackage

`default_nettype wire

// ----- rtl/cspss_channels.sv -----
// Valid/ready channel interfaces for request, response and register words.
`timescale 1ns / 1ps
`default_nettype none

interface cspss_req_if;
   logic                    valid;
   logic                    ready;
   cspss_pkg::req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface cspss_rsp_if;
   logic                    valid;
   logic                    ready;
   cspss_pkg::rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface cspss_csr_if;
   logic                    valid;
   logic                    ready;
   cspss_pkg::csr_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

// ----- rtl/convex_support_point_search_core.sv -----
// Convex support point search core: vertex store, affine transform and max-dot scan.
//
// Usage:
//  - req_ch takes one word per handshake. A load word (kind = load) writes one model-space
//    vertex into the store in the accepting cycle; slots at or past VERTEX_DEPTH are dropped.
//    A query word (kind = query) starts a scan over slots 0 .. count-1, count clipped to [1, VERTEX_DEPTH].
//  - csr_ch is always ready; writes are registered. Write only while the core is idle.
//  - rsp_ch returns one word per query: the world point with the greatest dot product
//    with the direction, earliest slot on ties, coordinates saturated to Q16.16.
// Throughput:
//  - loads: one per cycle, back to back, while no query is in flight.
//  - query: req_ready is low from acceptance until the result leaves the drain state.
//    The scan reads one vertex per cycle from the single-port store, which sets the rate.
//  - Pipeline: store read, 9 coefficient products, world sum + saturate, 3 dot products,
//    dot sum, best compare.
// Reset: synchronous, clears control and config; the store is not cleared and a slot must
//    be loaded before a query reaches it.
// Stall: rsp is held in an output register; a new word is accepted while it waits. A
//    finished query that meets a still-full output register waits in the drain state.
`timescale 1ns / 1ps
`default_nettype none

module convex_support_point_search_core #(
   parameter int VERTEX_DEPTH = 256,
   parameter int COORD_BITS   = 16
) (
   input  wire logic      clock,
   input  wire logic      reset,
   cspss_req_if.sink      req_ch,
   cspss_rsp_if.source    rsp_ch,
   cspss_csr_if.sink      csr_ch
);

   localparam int AW  = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
   localparam int CB  = COORD_BITS;
   localparam int PW  = cspss_pkg::COEF_BITS + CB;      // coef * coord
   localparam int WSW = PW + 2;                          // three products + offset
   localparam int DPW = cspss_pkg::WORLD_BITS + cspss_pkg::DIR_BITS;
   localparam int DW  = DPW + 2;
   localparam int WB  = cspss_pkg::WORLD_BITS;
   localparam int CW  = cspss_pkg::COEF_BITS;

   localparam logic signed [WSW-1:0] SAT_HI = WSW'(64'sh0000_0000_7FFF_FFFF);
   localparam logic signed [WSW-1:0] SAT_LO = WSW'(64'shFFFF_FFFF_8000_0000);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN} state_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } tag_type;

   // ---------------- config registers ----------------
   logic [cspss_pkg::ROW_BITS-1:0]   row_ff [3];
   logic [cspss_pkg::COUNT_BITS-1:0] vcount_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= cspss_pkg::ROW_X_RESET;
         row_ff[1] <= cspss_pkg::ROW_Y_RESET;
         row_ff[2] <= cspss_pkg::ROW_Z_RESET;
         vcount_ff <= cspss_pkg::COUNT_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.word.reg_index)
            cspss_pkg::CSR_ROW_X:        row_ff[0] <= csr_ch.word.reg_data;
            cspss_pkg::CSR_ROW_Y:        row_ff[1] <= csr_ch.word.reg_data;
            cspss_pkg::CSR_ROW_Z:        row_ff[2] <= csr_ch.word.reg_data;
            cspss_pkg::CSR_VERTEX_COUNT:
               vcount_ff <= csr_ch.word.reg_data[cspss_pkg::COUNT_BITS-1:0];
            default: ;  // unknown index, dropped
         endcase
      end
   end

   // ---------------- control ----------------
   state_type                     state_ff;
   logic [AW-1:0]                 addr_ff;
   logic [AW-1:0]                 last_ff;
   logic [AW-1:0]                 last_in;
   logic signed [cspss_pkg::DIR_BITS-1:0] dir_ff [3];
   logic                          done_ff;
   logic                          rsp_valid_ff;
   cspss_pkg::rsp_word_type       rsp_word_ff;

   logic req_take;
   logic load_wr;
   logic query_go;
   logic scan_rd;
   logic rsp_load;

   tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff;
   logic signed [WB-1:0] best_pt_ff [3];

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign load_wr      = req_take && (req_ch.word.kind == cspss_pkg::KIND_LOAD)
                         && (32'(req_ch.word.vert_index) < 32'(VERTEX_DEPTH));
   assign query_go     = req_take && (req_ch.word.kind == cspss_pkg::KIND_QUERY);
   assign scan_rd      = (state_ff == ST_SCAN);
   // last vertex has cleared the compare and the output register is free
   assign rsp_load     = (state_ff == ST_DRAIN) && done_ff && (!rsp_valid_ff || rsp_ch.ready);

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.word  = rsp_word_ff;

   // last slot searched: count clipped to [1, VERTEX_DEPTH]
   always_comb begin
      if (32'(vcount_ff) > 32'(VERTEX_DEPTH)) begin
         last_in = AW'(VERTEX_DEPTH - 1);
      end else if (vcount_ff == '0) begin
         last_in = '0;
      end else begin
         last_in = AW'(vcount_ff - cspss_pkg::COUNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         addr_ff      <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (tag5_ff.valid && tag5_ff.last) begin
            done_ff <= 1'b1;
         end
         case (state_ff)
            ST_IDLE: begin
               if (query_go) begin
                  state_ff  <= ST_SCAN;
                  addr_ff   <= '0;
                  last_ff   <= last_in;
                  dir_ff[0] <= req_ch.word.dir_x;
                  dir_ff[1] <= req_ch.word.dir_y;
                  dir_ff[2] <= req_ch.word.dir_z;
               end
            end
            ST_SCAN: begin
               if (addr_ff == last_ff) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  addr_ff <= addr_ff + AW'(1);
               end
            end
            ST_DRAIN: begin
               // wait for the last vertex to clear the compare, then for a free output
               if (rsp_load) begin
                  done_ff             <= 1'b0;
                  rsp_word_ff.point_x <= best_pt_ff[0];
                  rsp_word_ff.point_y <= best_pt_ff[1];
                  rsp_word_ff.point_z <= best_pt_ff[2];
                  state_ff            <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // ---------------- vertex store ----------------
   // entry: z, y, x from msb down, each CB bits two's complement
   logic [3*CB-1:0] vstore_mem [VERTEX_DEPTH];
   logic [3*CB-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (load_wr) begin
         vstore_mem[AW'(req_ch.word.vert_index)] <= {CB'(req_ch.word.vert_z),
                                                     CB'(req_ch.word.vert_y),
                                                     CB'(req_ch.word.vert_x)};
      end
      if (scan_rd) begin
         rd_data_ff <= vstore_mem[addr_ff];
      end
   end

   // ---------------- scan pipeline ----------------
   logic signed [PW-1:0]  prod_in [3][3];
   logic signed [PW-1:0]  prod_ff [3][3];
   logic signed [WSW-1:0] offs_in [3];
   logic signed [WSW-1:0] offs_ff [3];
   logic signed [WSW-1:0] wsum    [3];
   logic signed [WB-1:0]  world_in  [3];
   logic signed [WB-1:0]  world3_ff [3];
   logic signed [WB-1:0]  world4_ff [3];
   logic signed [WB-1:0]  world5_ff [3];
   logic signed [DPW-1:0] dprod_in [3];
   logic signed [DPW-1:0] dprod_ff [3];
   logic signed [DW-1:0]  dot_in;
   logic signed [DW-1:0]  dot_ff;
   logic signed [DW-1:0]  best_dot_ff;
   logic                  best_take;

   // stage 2: row coefficients times model coordinates
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[r][k] = PW'(signed'(row_ff[r][CW*k +: CW]))
                          * PW'(signed'(rd_data_ff[CB*k +: CB]));
         end
         offs_in[r] = WSW'(signed'(row_ff[r][CW*3 +: CW])) <<< cspss_pkg::OFFSET_SHIFT;
      end
   end

   // stage 3: world coordinate, saturated to Q16.16
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         wsum[r] = WSW'(prod_ff[r][0]) + WSW'(prod_ff[r][1]) + WSW'(prod_ff[r][2])
                 + offs_ff[r];
         if (wsum[r] > SAT_HI) begin
            world_in[r] = SAT_HI[WB-1:0];
         end else if (wsum[r] < SAT_LO) begin
            world_in[r] = SAT_LO[WB-1:0];
         end else begin
            world_in[r] = wsum[r][WB-1:0];
         end
      end
   end

   // stage 4 / 5: dot with the direction
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         dprod_in[r] = DPW'(world3_ff[r]) * DPW'(dir_ff[r]);
      end
      dot_in = DW'(dprod_ff[0]) + DW'(dprod_ff[1]) + DW'(dprod_ff[2]);
   end

   // strict greater keeps the earliest vertex on ties
   assign best_take = tag5_ff.valid && (tag5_ff.first || (dot_ff > best_dot_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
         tag5_ff <= '0;
      end else begin
         tag1_ff <= '{valid: scan_rd, first: (addr_ff == '0), last: (addr_ff == last_ff)};
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
         tag5_ff <= tag4_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      offs_ff   <= offs_in;
      world3_ff <= world_in;
      dprod_ff  <= dprod_in;
      world4_ff <= world3_ff;
      dot_ff    <= dot_in;
      world5_ff <= world4_ff;
      if (best_take) begin
         best_dot_ff <= dot_ff;
         best_pt_ff  <= world5_ff;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/cspss_checker.sv -----
// Port-level checks for the convex support point search core, bound into the core.
`timescale 1ns / 1ps
`default_nettype none
`include "convex_support_point_search_core_macros.svh"

module cspss_checker (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic                    req_kind,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire cspss_pkg::rsp_word_type rsp_word
);

   // queries accepted and not yet answered
   logic [1:0] pend_ff;
   logic       q_take;
   logic       l_take;
   logic       r_take;

   assign q_take = req_valid && req_ready && (req_kind == cspss_pkg::KIND_QUERY);
   assign l_take = req_valid && req_ready && (req_kind == cspss_pkg::KIND_LOAD);
   assign r_take = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 2'(q_take) - 2'(r_take);
      end
   end

   `CSPSS_ASSERT_NOW(a_rsp_has_query, rsp_valid, pend_ff != 2'd0)
   `CSPSS_ASSERT_NEXT(a_query_blocks_req, q_take, !req_ready)
   `CSPSS_ASSERT_NEXT(a_load_keeps_ready, l_take, req_ready)
   `CSPSS_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

endmodule

bind convex_support_point_search_core cspss_checker u_cspss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_kind  (req_ch.word.kind),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_word  (rsp_ch.word)
);

`default_nettype wire

// ----- verif/tb_convex_support_point_search_core.sv -----
// Testbench for the convex support point search core: directed table, then randomized phases.
`timescale 1ns / 1ps

module tb_convex_support_point_search_core;

   // Store depth and the settle time before a register write. A query may scan
   // the whole store, and a finished query may still sit in the drain state.
   localparam int DEPTH         = 256;
   localparam int SETTLE_CYCLES = DEPTH + 16;
   localparam int NUM_PHASES    = 12;
   localparam int HOLD_CYCLES   = 600;
   localparam int HOLD_AFTER    = 40;

   // First index past the defined registers; writes there must be dropped.
   localparam logic [cspss_pkg::CSR_INDEX_BITS-1:0] CSR_FIRST_UNUSED = 3'd4;

   localparam longint WORLD_MAX = (longint'(1) <<< (cspss_pkg::WORLD_BITS - 1)) - 1;
   localparam longint WORLD_MIN = -(longint'(1) <<< (cspss_pkg::WORLD_BITS - 1));

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // One row of the directed table: a request word or a register write.
   typedef struct {
      row_kind_type            kind;
      cspss_pkg::req_word_type word;
      cspss_pkg::csr_word_type csr;
      bit                      has_exp;
      cspss_pkg::rsp_word_type exp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cspss_req_if req_ch ();
   cspss_rsp_if rsp_ch ();
   cspss_csr_if csr_ch ();

   convex_support_point_search_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // Shadow of the block: vertex store, matrix rows and vertex count.
   logic signed [cspss_pkg::COEF_BITS-1:0] model_vert [DEPTH][3];
   bit                                     vert_written [DEPTH];
   logic [cspss_pkg::ROW_BITS-1:0]         cfg_row [3];
   logic [cspss_pkg::COUNT_BITS-1:0]       cfg_count;

   // Support points still owed by the block, oldest first.
   cspss_pkg::rsp_word_type pending_points [$];
   cspss_pkg::rsp_word_type exp_point;

   int error_count    = 0;
   int items_sent     = 0;
   int queries_sent   = 0;
   int points_checked = 0;
   int csr_writes     = 0;
   bit no_idle        = 1'b0;
   bit hold_done      = 1'b0;

   stim_row_type directed [$];

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   // Signed Q8.8 coefficient k of a packed matrix row.
   function automatic longint coef_of(logic [cspss_pkg::ROW_BITS-1:0] row, int k);
      logic signed [cspss_pkg::COEF_BITS-1:0] c;
      c = row[cspss_pkg::COEF_BITS*k +: cspss_pkg::COEF_BITS];
      return c;
   endfunction

   // World coordinate of a stored vertex for one matrix row, Q16.16, saturated.
   function automatic logic signed [cspss_pkg::WORLD_BITS-1:0] world_of(
         logic [cspss_pkg::ROW_BITS-1:0] row, int slot);
      longint s;
      s = coef_of(row, 0) * longint'(model_vert[slot][0])
        + coef_of(row, 1) * longint'(model_vert[slot][1])
        + coef_of(row, 2) * longint'(model_vert[slot][2])
        + (coef_of(row, 3) <<< cspss_pkg::OFFSET_SHIFT);
      if (s > WORLD_MAX) return WORLD_MAX[cspss_pkg::WORLD_BITS-1:0];
      if (s < WORLD_MIN) return WORLD_MIN[cspss_pkg::WORLD_BITS-1:0];
      return s[cspss_pkg::WORLD_BITS-1:0];
   endfunction

   // Furthest world point along the query direction; earliest slot on ties.
   function automatic cspss_pkg::rsp_word_type support_point(cspss_pkg::req_word_type w);
      int                                      n;
      longint                                  dot;
      longint                                  best_dot;
      logic signed [cspss_pkg::WORLD_BITS-1:0] wx;
      logic signed [cspss_pkg::WORLD_BITS-1:0] wy;
      logic signed [cspss_pkg::WORLD_BITS-1:0] wz;
      cspss_pkg::rsp_word_type                 best;
      // count zero still searches slot 0; counts past the store clip to its depth
      n = (cfg_count == 0) ? 1 : ((cfg_count > DEPTH) ? DEPTH : int'(cfg_count));
      best     = '0;
      best_dot = 0;
      for (int i = 0; i < n; i++) begin
         wx  = world_of(cfg_row[0], i);
         wy  = world_of(cfg_row[1], i);
         wz  = world_of(cfg_row[2], i);
         dot = longint'(wx) * longint'($signed(w.dir_x))
             + longint'(wy) * longint'($signed(w.dir_y))
             + longint'(wz) * longint'($signed(w.dir_z));
         if (i == 0 || dot > best_dot) begin
            best_dot      = dot;
            best.point_x  = wx;
            best.point_y  = wy;
            best.point_z  = wz;
         end
      end
      return best;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------

   function automatic stim_row_type load_row(logic [7:0] slot, logic [15:0] x, logic [15:0] y,
                                             logic [15:0] z);
      stim_row_type r;
      r.kind            = ROW_ITEM;
      r.word            = '0;
      r.word.kind       = cspss_pkg::KIND_LOAD;
      r.word.vert_index = slot;
      r.word.vert_x     = x;
      r.word.vert_y     = y;
      r.word.vert_z     = z;
      r.csr             = '0;
      r.has_exp         = 1'b0;
      r.exp             = '0;
      return r;
   endfunction

   function automatic stim_row_type query_row(logic [15:0] dx, logic [15:0] dy,
                                              logic [15:0] dz, bit has_exp,
                                              logic [31:0] px, logic [31:0] py,
                                              logic [31:0] pz);
      stim_row_type r;
      r.kind         = ROW_ITEM;
      r.word         = '0;
      r.word.kind    = cspss_pkg::KIND_QUERY;
      r.word.dir_x   = dx;
      r.word.dir_y   = dy;
      r.word.dir_z   = dz;
      r.csr          = '0;
      r.has_exp      = has_exp;
      r.exp.point_x  = px;
      r.exp.point_y  = py;
      r.exp.point_z  = pz;
      return r;
   endfunction

   function automatic stim_row_type csr_row(logic [cspss_pkg::CSR_INDEX_BITS-1:0] idx,
                                            logic [cspss_pkg::ROW_BITS-1:0] data);
      stim_row_type r;
      r.kind         = ROW_CSR;
      r.word         = '0;
      r.csr.reg_index = idx;
      r.csr.reg_data  = data;
      r.has_exp      = 1'b0;
      r.exp          = '0;
      return r;
   endfunction

   // Coordinates lean on the extremes and on a few small values so ties happen.
   function automatic logic [15:0] rand_coord();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3, 4: return {8'($urandom_range(4)), 8'h00};
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_dir();
      if ($urandom_range(3) == 0) return 16'h0000;
      return rand_coord();
   endfunction

   function automatic logic [cspss_pkg::ROW_BITS-1:0] rand_row(int axis);
      logic [cspss_pkg::ROW_BITS-1:0] r;
      case ($urandom_range(5))
         0: r = cspss_pkg::ROW_BITS'(64'h0100) << (cspss_pkg::COEF_BITS * axis);
         1: r = 64'h7FFF_7FFF_7FFF_7FFF;
         2: r = 64'h8000_8000_8000_8000;
         3: begin
            for (int k = 0; k < 4; k++)
               r[cspss_pkg::COEF_BITS*k +: cspss_pkg::COEF_BITS] =
                  16'($urandom_range(1023)) - 16'd512;
         end
         default: r = {$urandom, $urandom};
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------

   // Random gap before a word: now and then valid is dropped before the word is offered.
   task automatic gap_req();
      int k;
      if (!no_idle && $urandom_range(99) < 5) begin
         k = $urandom_range(4, 1);
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (k - 1) @(negedge clock);
      end
   endtask

   // Offer one word, wait for the handshake, then fold it into the shadow.
   task automatic send_word(cspss_pkg::req_word_type w, bit has_exp,
                            cspss_pkg::rsp_word_type exp);
      gap_req();
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.word  <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      if (w.kind == cspss_pkg::KIND_QUERY) begin
         queries_sent++;
         pending_points.push_back(has_exp ? exp : support_point(w));
      end else begin
         model_vert[w.vert_index][0] = w.vert_x;
         model_vert[w.vert_index][1] = w.vert_y;
         model_vert[w.vert_index][2] = w.vert_z;
         vert_written[w.vert_index]  = 1'b1;
      end
   endtask

   // Idle the request side until every owed point is back, then let the core settle.
   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [cspss_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [cspss_pkg::ROW_BITS-1:0] data);
      @(negedge clock);
      csr_ch.valid          <= 1'b1;
      csr_ch.word.reg_index <= idx;
      csr_ch.word.reg_data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_writes++;
      case (idx)
         cspss_pkg::CSR_ROW_X:        cfg_row[0] = data;
         cspss_pkg::CSR_ROW_Y:        cfg_row[1] = data;
         cspss_pkg::CSR_ROW_Z:        cfg_row[2] = data;
         cspss_pkg::CSR_VERTEX_COUNT: cfg_count  = data[cspss_pkg::COUNT_BITS-1:0];
         default: ;  // unused index, the core must drop it
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic cspss_pkg::req_word_type rand_word(bit is_query, int n_eff);
      cspss_pkg::req_word_type w;
      w.kind   = is_query ? cspss_pkg::KIND_QUERY : cspss_pkg::KIND_LOAD;
      // loads mostly land inside the searched range so queries see them
      if ($urandom_range(99) < 70) w.vert_index = 8'($urandom_range(n_eff - 1));
      else w.vert_index = 8'($urandom_range(DEPTH - 1));
      w.vert_x = rand_coord();
      w.vert_y = rand_coord();
      w.vert_z = rand_coord();
      w.dir_x  = rand_dir();
      w.dir_y  = rand_dir();
      w.dir_z  = rand_dir();
      return w;
   endfunction

   // Load every slot below n that was never written, so no query reads garbage.
   task automatic fill_slots(int n);
      cspss_pkg::req_word_type w;
      for (int i = 0; i < n; i++) begin
         if (!vert_written[i]) begin
            w = rand_word(1'b0, 1);
            w.vert_index = 8'(i);
            send_word(w, 1'b0, '0);
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------

   // Ready idles at random; once, after some points have come back, it holds off
   // long enough for the core to fill its output register and stall requests.
   initial begin : rsp_drive
      int hold;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && points_checked >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            for (hold = 0; hold < HOLD_CYCLES; hold++) @(negedge clock);
         end
         rsp_ch.ready <= (no_idle || $urandom_range(99) >= 12);
      end
   end

   task automatic check_field(string name, logic [cspss_pkg::WORLD_BITS-1:0] e,
                              logic [cspss_pkg::WORLD_BITS-1:0] a);
      if (e !== a) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_points.size() == 0) begin
            $display("%0t: unexpected point, expected none, got %h %h %h", $time,
                     rsp_ch.word.point_x, rsp_ch.word.point_y, rsp_ch.word.point_z);
            error_count++;
         end else begin
            exp_point = pending_points.pop_front();
            check_field("point_x", exp_point.point_x, rsp_ch.word.point_x);
            check_field("point_y", exp_point.point_y, rsp_ch.word.point_y);
            check_field("point_z", exp_point.point_z, rsp_ch.word.point_z);
            points_checked++;
         end
      end
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------

   initial begin : stimulus
      int phase_count [NUM_PHASES] = '{1, 3, 8, 0, 2, 256, 5, 300, 16, 511, 4, 2};
      int phase_items [NUM_PHASES] = '{100, 100, 100, 80, 100, 30, 100, 20, 80, 20, 100, 100};
      int                             n_eff;
      int                             q_pct;
      logic [cspss_pkg::ROW_BITS-1:0] data;
      cspss_pkg::req_word_type        w;

      req_ch.valid <= 1'b0;
      req_ch.word  <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.word  <= '0;

      cfg_row[0] = cspss_pkg::ROW_X_RESET;
      cfg_row[1] = cspss_pkg::ROW_Y_RESET;
      cfg_row[2] = cspss_pkg::ROW_Z_RESET;
      cfg_count  = cspss_pkg::COUNT_RESET;
      for (int i = 0; i < DEPTH; i++) begin
         model_vert[i]   = '{default: '0};
         vert_written[i] = 1'b0;
      end

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed part. Under the reset matrix a world point is the vertex shifted
      // up by eight bits, so those rows carry their answer inline.
      directed.push_back(load_row(8'd0, 16'h0000, 16'h0000, 16'h0000));
      directed.push_back(query_row(16'h0000, 16'h0000, 16'h0000, 1'b1,
                                   32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
      directed.push_back(load_row(8'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      directed.push_back(query_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1,
                                   32'h007F_FF00, 32'h007F_FF00, 32'h007F_FF00));
      directed.push_back(load_row(8'd0, 16'h8000, 16'h8000, 16'h8000));
      directed.push_back(query_row(16'h8000, 16'h8000, 16'h8000, 1'b1,
                                   32'hFF80_0000, 32'hFF80_0000, 32'hFF80_0000));
      directed.push_back(load_row(8'd255, 16'h1234, 16'hEDCB, 16'h0001));
      // two vertices with equal x: a pure x direction is a tie
      directed.push_back(load_row(8'd0, 16'h0500, 16'h0100, 16'h0000));
      directed.push_back(load_row(8'd1, 16'h0500, 16'h0200, 16'h0000));
      // count zero searches slot 0 alone, so the larger y of slot 1 is missed
      directed.push_back(csr_row(cspss_pkg::CSR_VERTEX_COUNT, 64'd0));
      directed.push_back(query_row(16'h0000, 16'h7FFF, 16'h0000, 1'b1,
                                   32'h0005_0000, 32'h0001_0000, 32'h0000_0000));
      directed.push_back(csr_row(cspss_pkg::CSR_VERTEX_COUNT, 64'd2));
      directed.push_back(query_row(16'h0100, 16'h0000, 16'h0000, 1'b1,
                                   32'h0005_0000, 32'h0001_0000, 32'h0000_0000));
      directed.push_back(query_row(16'h0000, 16'h0100, 16'h0000, 1'b1,
                                   32'h0005_0000, 32'h0002_0000, 32'h0000_0000));
      // write to an unused index must leave every register alone
      directed.push_back(csr_row(CSR_FIRST_UNUSED + 3'd1, '1));
      directed.push_back(query_row(16'h0000, 16'h0100, 16'h0000, 1'b0, '0, '0, '0));
      // full-scale x row: world x saturates both ways
      directed.push_back(csr_row(cspss_pkg::CSR_ROW_X, 64'h7FFF_7FFF_7FFF_7FFF));
      directed.push_back(load_row(8'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      directed.push_back(load_row(8'd1, 16'h8000, 16'h8000, 16'h8000));
      directed.push_back(query_row(16'h0100, 16'h0000, 16'h0000, 1'b1,
                                   32'h7FFF_FFFF, 32'h007F_FF00, 32'h007F_FF00));
      directed.push_back(query_row(16'h8000, 16'h0000, 16'h0000, 1'b1,
                                   32'h8000_0000, 32'hFF80_0000, 32'hFF80_0000));
      directed.push_back(csr_row(cspss_pkg::CSR_ROW_Y, 64'h8000_8000_8000_8000));
      directed.push_back(csr_row(cspss_pkg::CSR_ROW_Z, 64'h0123_4567_89AB_CDEF));
      directed.push_back(query_row(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0, '0, '0, '0));
      directed.push_back(query_row(16'h0000, 16'h0000, 16'h0000, 1'b0, '0, '0, '0));

      foreach (directed[r]) begin
         if (directed[r].kind == ROW_CSR) begin
            drain_results();
            write_csr(directed[r].csr.reg_index, directed[r].csr.reg_data);
         end else begin
            send_word(directed[r].word, directed[r].has_exp, directed[r].exp);
         end
      end

      // Random phases: each one sets a new matrix and count while idle, fills any
      // unwritten slot in range, then mixes loads and queries.
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_results();
         no_idle = (p == 6);
         for (int a = 0; a < 3; a++) begin
            if (p == 0) data = cspss_pkg::ROW_X_RESET << (cspss_pkg::COEF_BITS * a);
            else if (p == NUM_PHASES - 1) data = 64'h7FFF_7FFF_7FFF_7FFF;
            else if (p == NUM_PHASES - 2) data = 64'h8000_8000_8000_8000;
            else data = rand_row(a);
            write_csr(cspss_pkg::CSR_ROW_X + cspss_pkg::CSR_INDEX_BITS'(a), data);
         end
         data = {$urandom, $urandom};
         data[cspss_pkg::COUNT_BITS-1:0] = cspss_pkg::COUNT_BITS'(phase_count[p]);
         write_csr(cspss_pkg::CSR_VERTEX_COUNT, data);
         if ($urandom_range(2) == 0)
            write_csr(CSR_FIRST_UNUSED + cspss_pkg::CSR_INDEX_BITS'($urandom_range(3)),
                      {$urandom, $urandom});

         n_eff = (phase_count[p] == 0) ? 1
               : ((phase_count[p] > DEPTH) ? DEPTH : phase_count[p]);
         fill_slots(n_eff);
         // long scans are expensive; ask for fewer of them
         q_pct = (n_eff >= 64) ? 30 : 50;

         for (int i = 0; i < phase_items[p]; i++) begin
            // one mid-phase pause with the sender idle until all points are back
            if (p == 1 && i == phase_items[p] / 2) drain_results();
            w = rand_word($urandom_range(99) < q_pct, n_eff);
            send_word(w, 1'b0, '0);
         end
      end

      drain_results();
      $display("Run summary: %0d request words (%0d queries), %0d points checked,",
               items_sent, queries_sent, points_checked);
      $display("%0d register writes; counts from zero to past the store, saturation, ties, stalls.",
               csr_writes);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #40_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
